/* hw/rtl/class_b_ping_slot_scheduler_assert.svh */
// Assertion macros for the class B ping slot scheduler.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CLASS_B_PING_SLOT_SCHEDULER_ASSERT_SVH
`define CLASS_B_PING_SLOT_SCHEDULER_ASSERT_SVH

// Check that cons holds whenever ante holds.
`define CBPS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that expr holds at every clock edge out of reset.
`define CBPS_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

/* hw/rtl/cbps_pkg.sv */
// Package for the class B ping slot scheduler: widths, constants, codes,
// control word types and the microcode ROM. No dependencies.
package cbps_pkg;

  localparam int unsigned SEC_W      = 32;
  localparam int unsigned NS_W       = 30;
  localparam int unsigned LOG2_W     = 3;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned MIN_DLY_W  = 16;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PC_W       = 4;

  localparam int unsigned SIDX_W    = 21;
  localparam int unsigned TENTH_W   = 23;
  localparam int unsigned PROD_W    = 39;
  localparam int unsigned QEST_W    = 17;
  localparam int unsigned QSEC_W    = 16;
  localparam int unsigned RREM_W    = 24;
  localparam int unsigned REM_W     = 7;
  localparam int unsigned NSSUM_W   = 32;
  localparam int unsigned DS_W      = 33;
  localparam int unsigned DS_KEEP_W = 23;
  localparam int unsigned DNX_W     = 31;
  localparam int unsigned NS_LOW_W  = 6;
  localparam int unsigned Y_W       = 25;
  localparam int unsigned PROD2_W   = 50;
  localparam int unsigned AQ_W      = 12;
  localparam int unsigned AREM_W    = 26;
  localparam int unsigned FX_W      = 36;

  localparam logic [LOG2_W-1:0]    PING_NB_LOG2_RST = 3'd4;
  localparam logic [MIN_DLY_W-1:0] MIN_DELAY_RST    = 16'd300;

  localparam int unsigned SLOT_PERIOD_LOG2 = 12;
  localparam int unsigned SECOND_PERIOD_SEC = 128;
  localparam int unsigned TENTHS_PER_SLOT = 3;
  localparam int unsigned TENTHS_PER_SEC = 100;
  localparam int unsigned RECIP_100 = 41943;
  localparam int unsigned RECIP_100_SHIFT = 22;
  localparam int unsigned NS_PER_10MS = 10000000;
  localparam logic [NSSUM_W-1:0] NS_PER_SEC = 32'd1000000000;
  localparam int unsigned NS_BIAS = 1074000000;
  localparam int unsigned NS_BIAS_MS = 1074;
  localparam int unsigned DIV_15625 = 15625;
  localparam int unsigned RECIP_15625 = 17592186;
  localparam int unsigned RECIP_15625_SHIFT = 38;
  localparam int unsigned MS_PER_SEC = 1000;

  localparam logic [DELAY_W-1:0]    DELAY_MAX    = 32'h7FFF_FFFF;
  localparam logic [DELAY_W-1:0]    DELAY_MIN    = 32'h8000_0000;
  localparam logic signed [FX_W-1:0] FX_DELAY_MAX = 36'sd2147483647;
  localparam logic signed [FX_W-1:0] FX_DELAY_MIN = -36'sd2147483648;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_SEC     = 3'd0,
    REG_BASE_NS      = 3'd1,
    REG_PING_NB_LOG2 = 3'd2,
    REG_FIRST_SLOT   = 3'd3,
    REG_SECOND_SLOT  = 3'd4,
    REG_MIN_DELAY_MS = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RESTARTED  = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_FOUND_LAST = 2'd2,
    ST_FOUND_MORE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    UOP_IDLE, UOP_DISPATCH, UOP_RESTART, UOP_CHECK,
    UOP_SIDX, UOP_QEST, UOP_QFIX, UOP_NS,
    UOP_CARRY, UOP_DIFF, UOP_DIV1, UOP_DIV2,
    UOP_MS, UOP_CMP, UOP_FOUND, UOP_EXHAUST
  } uop_t;

  typedef enum logic [2:0] {
    JC_NONE, JC_ALWAYS, JC_NO_ITEM, JC_ACT_NEXT,
    JC_EXHAUSTED, JC_NS_OVER, JC_DELAY_LOW
  } jc_t;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_DISPATCH = 4'd1;
  localparam pc_t PC_RESTART  = 4'd2;
  localparam pc_t PC_CHECK    = 4'd3;
  localparam pc_t PC_SIDX     = 4'd4;
  localparam pc_t PC_QEST     = 4'd5;
  localparam pc_t PC_QFIX     = 4'd6;
  localparam pc_t PC_NS       = 4'd7;
  localparam pc_t PC_CARRY    = 4'd8;
  localparam pc_t PC_DIFF     = 4'd9;
  localparam pc_t PC_DIV1     = 4'd10;
  localparam pc_t PC_DIV2     = 4'd11;
  localparam pc_t PC_MS       = 4'd12;
  localparam pc_t PC_CMP      = 4'd13;
  localparam pc_t PC_FOUND    = 4'd14;
  localparam pc_t PC_EXHAUST  = 4'd15;

  typedef struct packed {
    uop_t uop;
    jc_t  jc;
    logic wait_out;
    pc_t  target;
  } uword_t;

  typedef struct packed {
    uop_t uop;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic no_item;
    logic act_next;
    logic exhausted;
    logic ns_over;
    logic delay_low;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode_rom(input pc_t addr);
    uword_t w;
    case (addr)
      PC_IDLE:     w = '{UOP_IDLE,     JC_NO_ITEM,   1'b0, PC_IDLE};
      PC_DISPATCH: w = '{UOP_DISPATCH, JC_ACT_NEXT,  1'b0, PC_CHECK};
      PC_RESTART:  w = '{UOP_RESTART,  JC_ALWAYS,    1'b1, PC_IDLE};
      PC_CHECK:    w = '{UOP_CHECK,    JC_EXHAUSTED, 1'b0, PC_EXHAUST};
      PC_SIDX:     w = '{UOP_SIDX,     JC_NONE,      1'b0, PC_IDLE};
      PC_QEST:     w = '{UOP_QEST,     JC_NONE,      1'b0, PC_IDLE};
      PC_QFIX:     w = '{UOP_QFIX,     JC_NONE,      1'b0, PC_IDLE};
      PC_NS:       w = '{UOP_NS,       JC_NONE,      1'b0, PC_IDLE};
      PC_CARRY:    w = '{UOP_CARRY,    JC_NS_OVER,   1'b0, PC_CARRY};
      PC_DIFF:     w = '{UOP_DIFF,     JC_NONE,      1'b0, PC_IDLE};
      PC_DIV1:     w = '{UOP_DIV1,     JC_NONE,      1'b0, PC_IDLE};
      PC_DIV2:     w = '{UOP_DIV2,     JC_NONE,      1'b0, PC_IDLE};
      PC_MS:       w = '{UOP_MS,       JC_NONE,      1'b0, PC_IDLE};
      PC_CMP:      w = '{UOP_CMP,      JC_DELAY_LOW, 1'b0, PC_CHECK};
      PC_FOUND:    w = '{UOP_FOUND,    JC_ALWAYS,    1'b1, PC_IDLE};
      PC_EXHAUST:  w = '{UOP_EXHAUST,  JC_ALWAYS,    1'b1, PC_IDLE};
      default:     w = '{UOP_IDLE,     JC_ALWAYS,    1'b0, PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/cbps_in_if.sv */
// Request channel of the ping slot scheduler: valid/ready plus request fields.
// Depends on cbps_pkg for field widths.
interface cbps_in_if import cbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SEC_W-1:0]  now_sec;
  logic [NS_W-1:0]   now_ns;

  modport source (output valid, action, now_sec, now_ns, input ready);
  modport sink   (input valid, action, now_sec, now_ns, output ready);
endinterface

/* hw/rtl/cbps_out_if.sv */
// Result channel of the ping slot scheduler: valid/ready plus result fields.
// Depends on cbps_pkg for field widths.
interface cbps_out_if import cbps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [SEC_W-1:0]          slot_sec;
  logic [NS_W-1:0]           slot_ns;
  logic signed [DELAY_W-1:0] delay_ms;

  modport source (output valid, status, slot_sec, slot_ns, delay_ms, input ready);
  modport sink   (input valid, status, slot_sec, slot_ns, delay_ms, output ready);
endinterface

/* hw/rtl/cbps_sequencer.sv */
// Microcode sequencer: step counter, control ROM from cbps_pkg, conditional jumps.
// Depends on cbps_pkg.
module cbps_sequencer import cbps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  uword_t word;
  logic   take;
  logic   stall;

  assign word  = ucode_rom(pc_r);
  assign stall = word.wait_out && flags.out_busy;

  always_comb begin
    case (word.jc)
      JC_NONE:      take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NO_ITEM:   take = flags.no_item;
      JC_ACT_NEXT:  take = flags.act_next;
      JC_EXHAUSTED: take = flags.exhausted;
      JC_NS_OVER:   take = flags.ns_over;
      JC_DELAY_LOW: take = flags.delay_low;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_comb begin
    ctrl.uop = word.uop;
    ctrl.go  = !stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* hw/rtl/class_b_ping_slot_scheduler.sv */
// Class B ping slot scheduler, top level: configuration registers, datapath,
// result register. Depends on cbps_pkg, cbps_in_if, cbps_out_if, cbps_sequencer.
//
// A restart request (action 0) loads a try budget of twice the slots per
// period and writes its status 0 result to the output register. A next
// request (action 1) passes a dispatch step, then per try the budget check,
// slot index, quotient estimate and fix, nanosecond sum and carry (repeated
// per carry), difference, divide estimate and fix, milliseconds and compare.
// It emits a found slot, or an exhausted result when the budget is spent.
// The rate is set by the single datapath that the sequencer steps one control
// word per cycle. A result step waits while the output register still holds an
// untaken result. One request is in flight at a time; a new request is taken as
// soon as the previous result sits in the output register.
// Configuration writes take effect on the next cycle and belong to idle time.
`include "class_b_ping_slot_scheduler_assert.svh"

module class_b_ping_slot_scheduler import cbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbps_in_if.sink               in_ch,
  cbps_out_if.source            out_ch
);

  ctrl_t  ctrl;
  flags_t flags;

  logic [SEC_W-1:0]     base_sec_r, base_sec_nxt;
  logic [NS_W-1:0]      base_ns_r, base_ns_nxt;
  logic [LOG2_W-1:0]    log2_r, log2_nxt;
  logic [SLOT_W-1:0]    first_r, first_nxt;
  logic [SLOT_W-1:0]    second_r, second_nxt;
  logic [MIN_DLY_W-1:0] min_delay_r, min_delay_nxt;

  logic [CNT_W-1:0]  tries_r, tries_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0] offset_r, offset_nxt;
  logic [CNT_W-1:0]  budget_r, budget_nxt;

  logic              act_r, act_nxt;
  logic [SEC_W-1:0]  now_sec_r, now_sec_nxt;
  logic [NS_W-1:0]   now_ns_r, now_ns_nxt;
  logic              second_per_r, second_per_nxt;
  logic [TENTH_W-1:0] tenths_r, tenths_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [QSEC_W-1:0]  sec_r, sec_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [NSSUM_W-1:0] ns_r, ns_nxt;
  logic [SEC_W-1:0]   slot_sec_r, slot_sec_nxt;
  logic [DS_W-1:0]    ds_r, ds_nxt;
  logic [DNX_W-1:0]   dnx_r, dnx_nxt;
  logic [PROD2_W-1:0] prod2_r, prod2_nxt;
  logic [AQ_W-1:0]    a_r, a_nxt;
  logic               bnz_r, bnz_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SEC_W-1:0]   out_sec_r, out_sec_nxt;
  logic [NS_W-1:0]    out_ns_r, out_ns_nxt;
  logic [DELAY_W-1:0] out_delay_r, out_delay_nxt;
  logic               out_wr;

  logic [CNT_W-1:0]   nslots;
  logic [CNT_W-1:0]   nslots_p1;
  logic [CNT_W-1:0]   tries_inc;
  logic [CNT_W-1:0]   idx_m1;
  logic [3:0]         shamt;
  logic [SIDX_W-1:0]  sidx;
  logic [TENTH_W-1:0] tenths;
  logic [QEST_W-1:0]  q_est;
  logic [RREM_W-1:0]  q_rem;
  logic [NSSUM_W-1:0] ns_sum;
  logic [SEC_W-1:0]   sec_sum;
  logic [NSSUM_W-1:0] dnx_full;
  logic [Y_W-1:0]     y_val;
  logic [AQ_W-1:0]    a_est;
  logic [AREM_W-1:0]  a_rem;
  logic               ds_in_range;
  logic signed [FX_W-1:0] ds_ext;
  logic signed [FX_W-1:0] f_ms;
  logic signed [FX_W-1:0] ms_trunc;
  logic [DELAY_W-1:0] delay_sat;

  cbps_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign nslots    = CNT_W'(1) << log2_r;
  assign nslots_p1 = nslots + CNT_W'(1);
  assign tries_inc = tries_r + CNT_W'(1);
  assign idx_m1    = idx_r - CNT_W'(1);
  assign shamt     = 4'(SLOT_PERIOD_LOG2) - {1'b0, log2_r};
  assign sidx      = SIDX_W'(offset_r) + (SIDX_W'(idx_m1) << shamt);
  assign tenths    = TENTH_W'(sidx) * TENTH_W'(TENTHS_PER_SLOT);

  assign q_est = prod_r[PROD_W-1:RECIP_100_SHIFT];
  assign q_rem = RREM_W'(tenths_r) - RREM_W'(q_est) * RREM_W'(TENTHS_PER_SEC);

  assign ns_sum  = NSSUM_W'(base_ns_r) + NSSUM_W'(rem_r) * NSSUM_W'(NS_PER_10MS);
  assign sec_sum = base_sec_r + SEC_W'(sec_r)
                 + (second_per_r ? SEC_W'(SECOND_PERIOD_SEC) : SEC_W'(0));

  assign dnx_full = ns_r + NSSUM_W'(NS_BIAS) - NSSUM_W'(now_ns_r);

  assign y_val = dnx_r[DNX_W-1:NS_LOW_W];
  assign a_est = prod2_r[PROD2_W-1:RECIP_15625_SHIFT];
  assign a_rem = AREM_W'(y_val) - AREM_W'(a_est) * AREM_W'(DIV_15625);

  assign ds_in_range = (ds_r[DS_W-1:DS_KEEP_W-1] == '0)
                    || (ds_r[DS_W-1:DS_KEEP_W-1] == '1);
  assign ds_ext   = $signed({{(FX_W-DS_KEEP_W){ds_r[DS_KEEP_W-1]}}, ds_r[DS_KEEP_W-1:0]});
  assign f_ms     = ds_ext * $signed(FX_W'(MS_PER_SEC)) + $signed(FX_W'(a_r))
                  - $signed(FX_W'(NS_BIAS_MS));
  assign ms_trunc = f_ms + $signed(FX_W'(f_ms[FX_W-1] && bnz_r));

  always_comb begin
    if (!ds_in_range) begin
      delay_sat = ds_r[DS_W-1] ? DELAY_MIN : DELAY_MAX;
    end else if (ms_trunc > FX_DELAY_MAX) begin
      delay_sat = DELAY_MAX;
    end else if (ms_trunc < FX_DELAY_MIN) begin
      delay_sat = DELAY_MIN;
    end else begin
      delay_sat = ms_trunc[DELAY_W-1:0];
    end
  end

  assign flags.no_item   = !in_ch.valid;
  assign flags.act_next  = act_r;
  assign flags.exhausted = tries_r >= budget_r;
  assign flags.ns_over   = ns_r >= NS_PER_SEC;
  assign flags.delay_low = $signed(delay_r) < $signed(DELAY_W'(min_delay_r));
  assign flags.out_busy  = out_valid_r && !out_ch.ready;

  assign out_wr = ctrl.go && ((ctrl.uop == UOP_RESTART) || (ctrl.uop == UOP_FOUND)
                              || (ctrl.uop == UOP_EXHAUST));

  always_comb begin
    base_sec_nxt   = base_sec_r;
    base_ns_nxt    = base_ns_r;
    log2_nxt       = log2_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    min_delay_nxt  = min_delay_r;
    tries_nxt      = tries_r;
    idx_nxt        = idx_r;
    offset_nxt     = offset_r;
    budget_nxt     = budget_r;
    act_nxt        = act_r;
    now_sec_nxt    = now_sec_r;
    now_ns_nxt     = now_ns_r;
    second_per_nxt = second_per_r;
    tenths_nxt     = tenths_r;
    prod_nxt       = prod_r;
    sec_nxt        = sec_r;
    rem_nxt        = rem_r;
    ns_nxt         = ns_r;
    slot_sec_nxt   = slot_sec_r;
    ds_nxt         = ds_r;
    dnx_nxt        = dnx_r;
    prod2_nxt      = prod2_r;
    a_nxt          = a_r;
    bnz_nxt        = bnz_r;
    delay_nxt      = delay_r;
    out_status_nxt = out_status_r;
    out_sec_nxt    = out_sec_r;
    out_ns_nxt     = out_ns_r;
    out_delay_nxt  = out_delay_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (ctrl.go) begin
      case (ctrl.uop)
        UOP_IDLE: begin
          if (in_ch.valid) begin
            act_nxt     = in_ch.action;
            now_sec_nxt = in_ch.now_sec;
            now_ns_nxt  = in_ch.now_ns;
          end
        end
        UOP_RESTART: begin
          budget_nxt     = {nslots[CNT_W-2:0], 1'b0};
          offset_nxt     = first_r;
          tries_nxt      = '0;
          idx_nxt        = '0;
          out_status_nxt = ST_RESTARTED;
          out_sec_nxt    = '0;
          out_ns_nxt     = '0;
          out_delay_nxt  = '0;
        end
        UOP_CHECK: begin
          if (!flags.exhausted) begin
            tries_nxt      = tries_inc;
            idx_nxt        = idx_r + CNT_W'(1);
            second_per_nxt = tries_inc >= nslots_p1;
            if (tries_inc == nslots_p1) begin
              idx_nxt    = CNT_W'(1);
              offset_nxt = second_r;
            end
          end
        end
        UOP_SIDX: begin
          tenths_nxt = tenths;
        end
        UOP_QEST: begin
          prod_nxt = PROD_W'(tenths_r) * PROD_W'(RECIP_100);
        end
        UOP_QFIX: begin
          if (q_rem >= RREM_W'(TENTHS_PER_SEC)) begin
            sec_nxt = QSEC_W'(q_est + QEST_W'(1));
            rem_nxt = REM_W'(q_rem - RREM_W'(TENTHS_PER_SEC));
          end else begin
            sec_nxt = QSEC_W'(q_est);
            rem_nxt = REM_W'(q_rem);
          end
        end
        UOP_NS: begin
          ns_nxt       = ns_sum;
          slot_sec_nxt = sec_sum;
        end
        UOP_CARRY: begin
          if (flags.ns_over) begin
            ns_nxt       = ns_r - NS_PER_SEC;
            slot_sec_nxt = slot_sec_r + SEC_W'(1);
          end
        end
        UOP_DIFF: begin
          ds_nxt  = {1'b0, slot_sec_r} - {1'b0, now_sec_r};
          dnx_nxt = dnx_full[DNX_W-1:0];
        end
        UOP_DIV1: begin
          prod2_nxt = PROD2_W'(y_val) * PROD2_W'(RECIP_15625);
        end
        UOP_DIV2: begin
          if (a_rem >= AREM_W'(DIV_15625)) begin
            a_nxt   = a_est + AQ_W'(1);
            bnz_nxt = (a_rem != AREM_W'(DIV_15625)) || (dnx_r[NS_LOW_W-1:0] != '0);
          end else begin
            a_nxt   = a_est;
            bnz_nxt = (a_rem != '0) || (dnx_r[NS_LOW_W-1:0] != '0);
          end
        end
        UOP_MS: begin
          delay_nxt = delay_sat;
        end
        UOP_FOUND: begin
          out_status_nxt = ({1'b0, tries_r} + (CNT_W+1)'(1) > {1'b0, budget_r})
                         ? ST_FOUND_LAST : ST_FOUND_MORE;
          out_sec_nxt    = slot_sec_r;
          out_ns_nxt     = ns_r[NS_W-1:0];
          out_delay_nxt  = delay_r;
        end
        UOP_EXHAUST: begin
          out_status_nxt = ST_EXHAUSTED;
          out_sec_nxt    = '0;
          out_ns_nxt     = '0;
          out_delay_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    if (out_wr) begin
      out_valid_nxt = 1'b1;
    end

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BASE_SEC:     base_sec_nxt  = cfg_wdata[SEC_W-1:0];
        REG_BASE_NS:      base_ns_nxt   = cfg_wdata[NS_W-1:0];
        REG_PING_NB_LOG2: log2_nxt      = cfg_wdata[LOG2_W-1:0];
        REG_FIRST_SLOT:   first_nxt     = cfg_wdata[SLOT_W-1:0];
        REG_SECOND_SLOT:  second_nxt    = cfg_wdata[SLOT_W-1:0];
        REG_MIN_DELAY_MS: min_delay_nxt = cfg_wdata[MIN_DLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sec_r  <= '0;
      base_ns_r   <= '0;
      log2_r      <= PING_NB_LOG2_RST;
      first_r     <= '0;
      second_r    <= '0;
      min_delay_r <= MIN_DELAY_RST;
      tries_r     <= '0;
      idx_r       <= '0;
      offset_r    <= '0;
      budget_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_sec_r  <= base_sec_nxt;
      base_ns_r   <= base_ns_nxt;
      log2_r      <= log2_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      min_delay_r <= min_delay_nxt;
      tries_r     <= tries_nxt;
      idx_r       <= idx_nxt;
      offset_r    <= offset_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    now_sec_r    <= now_sec_nxt;
    now_ns_r     <= now_ns_nxt;
    second_per_r <= second_per_nxt;
    tenths_r     <= tenths_nxt;
    prod_r       <= prod_nxt;
    sec_r        <= sec_nxt;
    rem_r        <= rem_nxt;
    ns_r         <= ns_nxt;
    slot_sec_r   <= slot_sec_nxt;
    ds_r         <= ds_nxt;
    dnx_r        <= dnx_nxt;
    prod2_r      <= prod2_nxt;
    a_r          <= a_nxt;
    bnz_r        <= bnz_nxt;
    delay_r      <= delay_nxt;
    out_status_r <= out_status_nxt;
    out_sec_r    <= out_sec_nxt;
    out_ns_r     <= out_ns_nxt;
    out_delay_r  <= out_delay_nxt;
  end

  assign in_ch.ready     = (ctrl.uop == UOP_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.slot_sec = out_sec_r;
  assign out_ch.slot_ns  = out_ns_r;
  assign out_ch.delay_ms = $signed(out_delay_r);

  `CBPS_ASSERT_HOLDS(a_tries_in_budget, tries_r <= budget_r, "try count beyond budget")
  `CBPS_ASSERT_IMPLIES(a_rem_reduced, ctrl.uop == UOP_NS, rem_r < REM_W'(TENTHS_PER_SEC), "quotient correction left remainder of 100 or more")
  `CBPS_ASSERT_IMPLIES(a_ns_normalized, ctrl.uop == UOP_DIFF, ns_r < NS_PER_SEC, "nanoseconds not normalized after carry")
  `CBPS_ASSERT_IMPLIES(a_out_source, $rose(out_valid_r), $past(out_wr), "result appeared without a result step")

endmodule
